// ===== sv/frb_pkg.sv =====
// Shared types and constants for the FIR filter ring buffer unit.
// No dependencies; used by every module of the block.
package frb_pkg;

	// Field widths
	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 16;
	localparam int PROD_W      = SAMPLE_W + 1 + COEF_W;
	localparam int ACC_W       = 35;

	// Coefficient register file
	localparam int NUM_COEFS   = 8;
	localparam int COEF_IDX_W  = 3;
	localparam int CFG_IDX_W   = 8;

	// Control from the sequencer to the shared multiply-accumulate unit
	typedef struct packed {
		logic clear;   // zero the accumulator and drop any product in flight
		logic mul_en;  // multiply the current operands this cycle
	} mac_ctrl_t;

endpackage

// ===== sv/frb_ring.sv =====
// Ring delay line of TAPS samples with write pointer and full flag.
// Depends on frb_pkg.
module frb_ring #(
	parameter int TAPS = 8,
	parameter int AW   = $clog2(TAPS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [frb_pkg::SAMPLE_W-1:0] wr_data,
	input  logic [AW-1:0]                rd_addr,
	output logic [frb_pkg::SAMPLE_W-1:0] rd_data,
	output logic [AW-1:0]                wr_pos,
	output logic                         full
);

	localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

	logic [frb_pkg::SAMPLE_W-1:0] line_q [TAPS];
	logic [AW-1:0]                wr_pos_q;
	logic                         full_q;

	// Sample storage, cleared at reset so unwritten slots count as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				line_q[i] <= '0;
			end
		end else if (wr_en) begin
			line_q[wr_pos_q] <= wr_data;
		end
	end

	// Write pointer wraps at TAPS-1; the first wrap marks the line full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q <= '0;
			full_q   <= 1'b0;
		end else if (wr_en) begin
			if (wr_pos_q == LAST) begin
				wr_pos_q <= '0;
				full_q   <= 1'b1;
			end else begin
				wr_pos_q <= wr_pos_q + 1'b1;
			end
		end
	end

	assign rd_data = line_q[rd_addr];
	assign wr_pos  = wr_pos_q;
	assign full    = full_q;

endmodule

// ===== sv/frb_mac.sv =====
// Shared multiply-accumulate unit: one signed 16x17 product per cycle,
// registered, then summed into a 35-bit accumulator. Depends on frb_pkg.
module frb_mac (
	input  logic                             clk,
	input  logic                             arst_n,
	input  frb_pkg::mac_ctrl_t               ctrl,
	input  logic [frb_pkg::SAMPLE_W-1:0]     sample,
	input  logic signed [frb_pkg::COEF_W-1:0] coef,
	output logic signed [frb_pkg::ACC_W-1:0] acc
);

	logic signed [frb_pkg::PROD_W-1:0] product_s1;
	logic                              prod_vld_s1;
	logic signed [frb_pkg::ACC_W-1:0]  acc_q;
	logic signed [frb_pkg::ACC_W-1:0]  prod_ext;

	// Stage 1: multiply; sample is zero-extended to stay unsigned
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= ctrl.mul_en && !ctrl.clear;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			product_s1 <= coef * $signed({1'b0, sample});
		end
	end

	assign prod_ext = {{(frb_pkg::ACC_W - frb_pkg::PROD_W){product_s1[frb_pkg::PROD_W-1]}},
		product_s1};

	// Stage 2: accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	assign acc = acc_q;

endmodule

// ===== sv/fir_filter_ring_buffer_unit.sv =====
// Top level of the FIR filter ring buffer unit: sequencer, coefficient
// registers and result register. Depends on frb_pkg, frb_ring, frb_mac.
//
// Usage:
//   Input channel (in_valid/in_ready, sample) takes one unsigned 16-bit
//   sample per transaction. It is written into a TAPS-deep ring delay line.
//   Output channel (out_valid/out_ready, filtered, ring_full) returns one
//   result per sample: the signed Q.14 FIR sum over the last TAPS samples,
//   and whether the ring has wrapped at least once.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes coef_0..
//   coef_7 at indexes 0..7; other indexes are dropped. cfg_ready is always
//   high; write only while the filter is idle.
// Timing:
//   One multiply-accumulate per tap through a single shared multiplier. The
//   sequencer walks the taps in S_RUN, lets the last product accumulate in
//   S_DRAIN and loads the result register in S_DONE; in_ready returns as it
//   loads, so a new sample is taken only once the last one is through.
// Reset and stalls:
//   Reset clears the delay line, write pointer, full flag and coefficients.
//   A result waiting on out_ready holds the sequencer in its final state, so
//   no new sample is accepted until that result transaction completes.
module fir_filter_ring_buffer_unit #(
	parameter int TAPS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [frb_pkg::SAMPLE_W-1:0]      sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [frb_pkg::ACC_W-1:0]  filtered,
	output logic                              ring_full,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [frb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [frb_pkg::COEF_W-1:0]        cfg_data
);

	localparam int AW = $clog2(TAPS);
	localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t                             state_q;
	logic [AW-1:0]                      tap_q;
	logic [AW-1:0]                      rd_ptr_q;
	logic                               out_valid_q;
	logic signed [frb_pkg::ACC_W-1:0]   filtered_q;
	logic                               ring_full_q;
	logic signed [frb_pkg::COEF_W-1:0]  coef_q [frb_pkg::NUM_COEFS];

	logic                               in_accept;
	logic                               out_free;
	logic [AW-1:0]                      wr_pos_w;
	logic                               full_w;
	logic [frb_pkg::SAMPLE_W-1:0]       rd_data_w;
	logic signed [frb_pkg::ACC_W-1:0]   acc_w;
	logic [frb_pkg::COEF_IDX_W-1:0]     coef_idx;
	frb_pkg::mac_ctrl_t                 mac_ctrl;

	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	// Coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < frb_pkg::NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_index < frb_pkg::CFG_IDX_W'(frb_pkg::NUM_COEFS)) begin
			coef_q[cfg_index[frb_pkg::COEF_IDX_W-1:0]] <= cfg_data;
		end
	end

	frb_ring #(
		.TAPS (TAPS),
		.AW   (AW)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_accept),
		.wr_data (sample),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data_w),
		.wr_pos  (wr_pos_w),
		.full    (full_w)
	);

	// Tap k weights the sample k slots behind the newest
	assign coef_idx = frb_pkg::COEF_IDX_W'(tap_q);

	always_comb begin
		mac_ctrl.clear  = in_accept;
		mac_ctrl.mul_en = (state_q == S_RUN);
	end

	frb_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.sample (rd_data_w),
		.coef   (coef_q[coef_idx]),
		.acc    (acc_w)
	);

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tap_q       <= '0;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
			filtered_q  <= '0;
			ring_full_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						rd_ptr_q <= wr_pos_w;
						tap_q    <= '0;
						state_q  <= S_RUN;
					end
				end
				S_RUN: begin
					rd_ptr_q <= (rd_ptr_q == '0) ? LAST : rd_ptr_q - 1'b1;
					if (tap_q == LAST) begin
						state_q <= S_DRAIN;
					end else begin
						tap_q <= tap_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						filtered_q  <= acc_w;
						ring_full_q <= full_w;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign ring_full = ring_full_q;

	// Accepted sample starts the walk at tap zero
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == S_RUN) && (tap_q == '0))
		else $error("walk did not start at tap zero");

	// Last tap hands over to the accumulate drain
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) && (tap_q == LAST) |=> (state_q == S_DRAIN))
		else $error("sequencer skipped drain after last tap");

	// Read pointer never leaves the ring
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ptr_q <= LAST)
		else $error("read pointer outside delay line");

	// Full flag is sticky
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(full_w))
		else $error("ring full flag dropped");

	// A finished sum waits while the result register is still occupied
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && out_valid_q && !out_ready
		|=> (state_q == S_DONE) && out_valid_q)
		else $error("result register overwritten before transfer");

endmodule

// ===== tb/sv/fir_filter_ring_buffer_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for fir_filter_ring_buffer_unit: drives samples and
// coefficient writes, predicts every FIR sum and full flag, checks each result.
// Depends on frb_pkg and the fir_filter_ring_buffer_unit RTL.
module fir_filter_ring_buffer_unit_test;

	localparam int TAPS         = 8;
	localparam int CLK_HALF     = 6;
	localparam int DRAIN_CYCLES = TAPS + 8;
	localparam int COEF0_IDX    = 0;
	localparam int STRAY_IDX_LO = frb_pkg::NUM_COEFS;
	localparam int STRAY_IDX_HI = (1 << frb_pkg::CFG_IDX_W) - 1;

	localparam logic [frb_pkg::COEF_W-1:0] COEF_MIN = 16'h8000;
	localparam logic [frb_pkg::COEF_W-1:0] COEF_MAX = 16'h7FFF;
	localparam logic [frb_pkg::COEF_W-1:0] COEF_ONE = 16'h4000;

	// Tracks the delay line and coefficients, predicts each FIR sum
	class fir_sum_tracker;
		typedef struct {
			logic signed [frb_pkg::ACC_W-1:0] filtered;
			logic                             ring_full;
		} fir_result_t;

		logic [frb_pkg::SAMPLE_W-1:0]      delay_line [TAPS];
		logic signed [frb_pkg::COEF_W-1:0] coef [frb_pkg::NUM_COEFS];
		int                                wr_pos;
		bit                                full;
		fir_result_t                       pending_sums [$];
		int                                mismatch_count;

		function new();
			foreach (delay_line[i]) delay_line[i] = '0;
			foreach (coef[i]) coef[i] = '0;
			wr_pos = 0;
			full = 1'b0;
			mismatch_count = 0;
		endfunction

		// Writes to indexes past the coefficient file are dropped
		function void write_coef(int idx, logic [frb_pkg::COEF_W-1:0] data);
			if (idx < frb_pkg::NUM_COEFS)
				coef[idx] = data;
		endfunction

		// Accepted sample transaction: update the ring, queue the expected sum
		function void note_sample(logic [frb_pkg::SAMPLE_W-1:0] s);
			int          newest;
			int          idx;
			int          k;
			longint      acc;
			fir_result_t r;
			newest = wr_pos;
			delay_line[newest] = s;
			if (newest + 1 >= TAPS) begin
				wr_pos = 0;
				full = 1'b1;
			end else begin
				wr_pos = newest + 1;
			end
			// tap k weights the sample k steps before the newest
			acc = 0;
			for (k = 0; k < TAPS; k++) begin
				idx = (newest + TAPS - k) % TAPS;
				acc += longint'(coef[k]) * longint'(delay_line[idx]);
			end
			r.filtered = acc[frb_pkg::ACC_W-1:0];
			r.ring_full = full;
			pending_sums.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			mismatch_count++;
		endtask

		// Result transaction: compare against the oldest expected sum
		task check_result(logic signed [frb_pkg::ACC_W-1:0] got_sum, logic got_full);
			fir_result_t want;
			if (pending_sums.size() == 0) begin
				report_mismatch($sformatf("result with none expected, filtered=%0d", got_sum));
				return;
			end
			want = pending_sums.pop_front();
			if (got_sum !== want.filtered)
				report_mismatch($sformatf("filtered got %0d want %0d",
					got_sum, want.filtered));
			if (got_full !== want.ring_full)
				report_mismatch($sformatf("ring_full got %b want %b",
					got_full, want.ring_full));
		endtask
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	logic [frb_pkg::SAMPLE_W-1:0]      sample;
	logic                              out_valid;
	logic                              out_ready;
	logic signed [frb_pkg::ACC_W-1:0]  filtered;
	logic                              ring_full;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [frb_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [frb_pkg::COEF_W-1:0]        cfg_data;

	fir_sum_tracker             sums = new();
	logic [frb_pkg::COEF_W-1:0] coef_plan [frb_pkg::NUM_COEFS];
	bit                         quiet_tail = 1'b0;
	int                         in_idle_pct = 30;
	int                         out_idle_pct = 30;

	fir_filter_ring_buffer_unit #(.TAPS(TAPS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.filtered  (filtered),
		.ring_full (ring_full),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Run limit
	initial begin
		#5000000;
		$display("FAIL fir_filter_ring_buffer_unit");
		$finish;
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sums.check_result(filtered, ring_full);
	end

	// Result side back-pressure in random bursts
	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!quiet_tail && $urandom_range(1, 100) <= out_idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	function automatic logic [frb_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return frb_pkg::SAMPLE_W'($urandom_range(0, 15));
			3:       return frb_pkg::SAMPLE_W'(16'h8000 | $urandom_range(0, 15));
			default: return frb_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [frb_pkg::COEF_W-1:0] pick_coef();
		case ($urandom_range(0, 7))
			0:       return COEF_MIN;
			1:       return COEF_MAX;
			2:       return '0;
			3:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
			4:       return COEF_ONE;
			default: return frb_pkg::COEF_W'($urandom);
		endcase
	endfunction

	// Sample transaction, valid left high on return
	task send_sample(input logic [frb_pkg::SAMPLE_W-1:0] s);
		if (!quiet_tail && $urandom_range(1, 100) <= in_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sums.note_sample(s);
	endtask

	// Register write transaction, valid left high on return
	task write_reg(input int idx, input logic [frb_pkg::COEF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= frb_pkg::CFG_IDX_W'(idx);
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sums.write_coef(idx, data);
	endtask

	// All results back, then let the sequencer settle
	task wait_drained();
		while (sums.pending_sums.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Load coef_plan while idle, bracketed by writes to out-of-range indexes
	task program_coefs();
		int k;
		wait_drained();
		write_reg($urandom_range(STRAY_IDX_LO, STRAY_IDX_HI), frb_pkg::COEF_W'($urandom));
		for (k = 0; k < frb_pkg::NUM_COEFS; k++)
			write_reg(COEF0_IDX + k, coef_plan[k]);
		write_reg($urandom_range(STRAY_IDX_LO, STRAY_IDX_HI), frb_pkg::COEF_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Coefficients at reset value: every sum is zero while the ring starts filling
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		send_sample(16'h0001);
		in_valid <= 1'b0;

		// Distinct taps expose a rotated coefficient walk; ring wraps in this stretch
		coef_plan = '{16'h0001, 16'h0010, 16'hFF00, 16'h4000,
			16'hC000, 16'h0100, 16'h7FFF, 16'h8001};
		program_coefs();
		send_sample(16'h0001);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'hAAAA);
		send_sample(16'h5555);
		send_sample(16'hFFFF);
		in_valid <= 1'b0;

		// Most negative sum: all taps at minimum, ring full of maximum samples
		foreach (coef_plan[k]) coef_plan[k] = COEF_MIN;
		program_coefs();
		repeat (TAPS) send_sample(16'hFFFF);
		in_valid <= 1'b0;

		// Most positive sum
		foreach (coef_plan[k]) coef_plan[k] = COEF_MAX;
		program_coefs();
		repeat (3) send_sample(16'hFFFF);
		in_valid <= 1'b0;

		// Random phases, each with its own coefficients and idling mix; last has no idling
		for (int p = 0; p < 7; p++) begin
			foreach (coef_plan[k]) coef_plan[k] = pick_coef();
			case ($urandom_range(0, 2))
				0:       in_idle_pct = 0;
				1:       in_idle_pct = 15;
				default: in_idle_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0:       out_idle_pct = 0;
				1:       out_idle_pct = 15;
				default: out_idle_pct = 40;
			endcase
			program_coefs();
			if (p == 6)
				quiet_tail = 1'b1;
			repeat ((p == 6) ? 110 : 140) send_sample(pick_sample());
			in_valid <= 1'b0;
		end

		wait_drained();
		if (sums.mismatch_count == 0)
			$display("PASS fir_filter_ring_buffer_unit");
		else
			$display("FAIL fir_filter_ring_buffer_unit");
		$finish;
	end

endmodule
